@@ src/art_pkg.sv @@
// Shared types and codes for the allocation range table.
// Holds the request/result transfer types, the entry format and the
// controller-to-datapath command struct. No dependencies.
package art_pkg;

	localparam int FW = 48;
	localparam int EW = 32;
	localparam int PW = FW + EW;

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_CALLOC  = 3'd1;
	localparam logic [2:0] CMD_REALLOC = 3'd2;
	localparam logic [2:0] CMD_REMOVE  = 3'd3;
	localparam logic [2:0] CMD_LOOKUP  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_PRESENT   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [2:0]    command;
		logic [FW-1:0] address;
		logic [FW-1:0] new_address;
		logic [FW-1:0] length;
		logic [EW-1:0] element_size;
	} request_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [FW-1:0] block_start;
		logic [FW-1:0] block_length;
		logic [FW-1:0] block_offset;
	} result_t;

	typedef struct packed {
		logic          valid;
		logic          big;
		logic [FW-1:0] start;
		logic [FW-1:0] length;
	} entry_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic mul_sum;
		logic clear;
		logic scan;
		logic decide;
		logic wr_a;
		logic wr_b;
	} ctrl_t;

endpackage

@@ src/art_ctrl.sv @@
// Sequencing state machine for the allocation range table.
// Drives art_pkg::ctrl_t commands into the datapath; uses art_pkg.
module art_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          idx_last,
	output logic          busy,
	output logic          done,
	output art_pkg::ctrl_t ctrl
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_MUL0   = 4'd2;
	localparam logic [3:0] S_MUL1   = 4'd3;
	localparam logic [3:0] S_MUL2   = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_DRAIN  = 4'd6;
	localparam logic [3:0] S_DECIDE = 4'd7;
	localparam logic [3:0] S_WRA    = 4'd8;
	localparam logic [3:0] S_WRB    = 4'd9;
	localparam logic [3:0] S_RESP   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		done    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctrl.clear = 1'b1;
				if (idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctrl.load = start;
				if (start) begin
					state_d = S_MUL0;
				end
			end
			S_MUL0: begin
				ctrl.mul_lo = 1'b1;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				ctrl.mul_hi = 1'b1;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				ctrl.mul_sum = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				ctrl.scan = 1'b1;
				if (idx_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				ctrl.decide = 1'b1;
				state_d     = S_WRA;
			end
			S_WRA: begin
				ctrl.wr_a = 1'b1;
				state_d   = S_WRB;
			end
			S_WRB: begin
				ctrl.wr_b = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ src/art_dp.sv @@
// Datapath of the allocation range table: entry memory, scan index,
// shared multiplier, search registers and result. Uses art_pkg.
module art_dp #(
	parameter int CAPACITY     = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  art_pkg::ctrl_t    ctrl,
	input  art_pkg::request_t request,
	output logic              idx_last,
	output art_pkg::result_t  result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int FW = art_pkg::FW;
	localparam int EW = art_pkg::EW;
	localparam int PW = art_pkg::PW;
	localparam logic [PW-1:0] MASK = (PW'(1) << ADDRESS_BITS) - PW'(1);

	art_pkg::entry_t entry_q [CAPACITY];
	art_pkg::entry_t rd_s1;
	logic            rd_vld_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic [IW-1:0]   cnt_q;

	logic            we;
	logic [IW-1:0]   waddr;
	art_pkg::entry_t wdata;

	logic [2:0]    cmd_q;
	logic [FW-1:0] addr_q;
	logic [FW-1:0] naddr_q;
	logic [FW-1:0] len_q;
	logic [EW-1:0] esize_q;

	logic [EW-1:0]    mul_a;
	logic [2*EW-1:0]  prod;
	logic [2*EW-1:0]  p0_q;
	logic [FW-1:0]    p1_q;
	logic [PW-1:0]    sum;
	logic             ovf_q;
	logic             pbig_q;
	logic [FW-1:0]    plen_q;

	logic [FW-1:0] key;
	logic          m_found_q;
	logic [IW-1:0] m_idx_q;
	logic          o_found_q;
	logic [IW-1:0] o_idx_q;
	logic          f_found_q;
	logic [IW-1:0] f_idx_q;
	logic          b_found_q;
	logic [FW-1:0] b_start_q;
	logic [FW-1:0] b_len_q;
	logic          b_big_q;

	art_pkg::result_t res_d;
	art_pkg::result_t res_q;
	logic             wa_d;
	logic             wb_d;
	logic [IW-1:0]    wb_idx_d;
	logic [FW-1:0]    wb_start_d;
	logic [FW-1:0]    wb_len_d;
	logic             wb_big_d;
	logic             wa_q;
	logic             wb_q;
	logic [IW-1:0]    wb_idx_q;
	logic [FW-1:0]    wb_start_q;
	logic [FW-1:0]    wb_len_q;
	logic             wb_big_q;
	logic             use_m;
	logic             free_ok;
	logic [IW-1:0]    free_idx;
	logic [FW-1:0]    off;
	logic             hit;

	assign idx_last = (cnt_q == IW'(CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.scan;
			if (ctrl.clear || ctrl.scan) begin
				cnt_q <= idx_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = '0;
		if (ctrl.clear) begin
			we = 1'b1;
		end else if (ctrl.wr_a && wa_q) begin
			we    = 1'b1;
			waddr = o_idx_q;
		end else if (ctrl.wr_b && wb_q) begin
			we           = 1'b1;
			waddr        = wb_idx_q;
			wdata.valid  = 1'b1;
			wdata.big    = wb_big_q;
			wdata.start  = wb_start_q;
			wdata.length = wb_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q[waddr] <= wdata;
		end
		rd_s1     <= entry_q[cnt_q];
		rd_idx_s1 <= cnt_q;
	end

	assign mul_a = ctrl.mul_lo ? len_q[EW-1:0] : {{(2*EW-FW){1'b0}}, len_q[FW-1:EW]};
	assign prod  = mul_a * esize_q;
	assign sum   = {{(PW-2*EW){1'b0}}, p0_q} + {p1_q, {EW{1'b0}}};
	assign key   = (cmd_q == art_pkg::CMD_REALLOC) ? naddr_q : addr_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= request.command;
			addr_q    <= request.address & MASK[FW-1:0];
			naddr_q   <= request.new_address & MASK[FW-1:0];
			len_q     <= request.length & MASK[FW-1:0];
			esize_q   <= request.element_size;
			m_found_q <= 1'b0;
			o_found_q <= 1'b0;
			f_found_q <= 1'b0;
			b_found_q <= 1'b0;
		end
		if (ctrl.mul_lo) begin
			p0_q <= prod;
		end
		if (ctrl.mul_hi) begin
			p1_q <= prod[FW-1:0];
		end
		if (ctrl.mul_sum) begin
			ovf_q  <= (sum > MASK);
			pbig_q <= |sum[PW-1:FW];
			plen_q <= sum[FW-1:0];
		end
		if (rd_vld_s1) begin
			if (rd_s1.valid && rd_s1.start == key && !m_found_q) begin
				m_found_q <= 1'b1;
				m_idx_q   <= rd_idx_s1;
			end
			if (rd_s1.valid && rd_s1.start == addr_q && !o_found_q) begin
				o_found_q <= 1'b1;
				o_idx_q   <= rd_idx_s1;
			end
			if (!rd_s1.valid && !f_found_q) begin
				f_found_q <= 1'b1;
				f_idx_q   <= rd_idx_s1;
			end
			if (rd_s1.valid && rd_s1.start <= addr_q &&
			    (!b_found_q || rd_s1.start > b_start_q)) begin
				b_found_q <= 1'b1;
				b_start_q <= rd_s1.start;
				b_len_q   <= rd_s1.length;
				b_big_q   <= rd_s1.big;
			end
		end
		if (ctrl.decide) begin
			res_q      <= res_d;
			wa_q       <= wa_d;
			wb_q       <= wb_d;
			wb_idx_q   <= wb_idx_d;
			wb_start_q <= wb_start_d;
			wb_len_q   <= wb_len_d;
			wb_big_q   <= wb_big_d;
		end
	end

	assign use_m    = m_found_q && !(o_found_q && m_idx_q == o_idx_q);
	assign free_ok  = o_found_q || f_found_q;
	assign free_idx = (o_found_q && (!f_found_q || o_idx_q < f_idx_q)) ? o_idx_q : f_idx_q;
	assign off      = addr_q - b_start_q;
	assign hit      = b_found_q && (off == '0 || b_big_q || off < b_len_q);

	always_comb begin
		res_d        = '0;
		res_d.status = art_pkg::ST_NOT_FOUND;
		wa_d         = 1'b0;
		wb_d         = 1'b0;
		wb_idx_d     = f_idx_q;
		wb_start_d   = addr_q;
		wb_len_d     = len_q;
		wb_big_d     = 1'b0;
		case (cmd_q)
			art_pkg::CMD_ADD: begin
				if (m_found_q) begin
					res_d.status = art_pkg::ST_PRESENT;
				end else if (f_found_q) begin
					wb_d         = 1'b1;
					res_d.status = art_pkg::ST_OK;
				end else begin
					res_d.status = art_pkg::ST_FULL;
				end
			end
			art_pkg::CMD_CALLOC: begin
				wb_len_d = plen_q;
				wb_big_d = pbig_q;
				if (ovf_q) begin
					res_d.status = art_pkg::ST_OVERFLOW;
				end else if (m_found_q) begin
					wb_d         = 1'b1;
					wb_idx_d     = m_idx_q;
					res_d.status = art_pkg::ST_OK;
				end else if (f_found_q) begin
					wb_d         = 1'b1;
					res_d.status = art_pkg::ST_OK;
				end else begin
					res_d.status = art_pkg::ST_FULL;
				end
			end
			art_pkg::CMD_REALLOC: begin
				wb_start_d = naddr_q;
				if (use_m) begin
					wb_d         = 1'b1;
					wb_idx_d     = m_idx_q;
					res_d.status = art_pkg::ST_OK;
				end else if (free_ok) begin
					wb_d         = 1'b1;
					wb_idx_d     = free_idx;
					res_d.status = art_pkg::ST_OK;
				end else begin
					res_d.status = art_pkg::ST_FULL;
				end
				wa_d = o_found_q && !(wb_d && wb_idx_d == o_idx_q);
			end
			art_pkg::CMD_REMOVE: begin
				if (o_found_q) begin
					wa_d         = 1'b1;
					res_d.status = art_pkg::ST_OK;
				end
			end
			art_pkg::CMD_LOOKUP: begin
				if (hit) begin
					res_d.status       = art_pkg::ST_OK;
					res_d.block_start  = b_start_q;
					res_d.block_length = b_len_q;
					res_d.block_offset = off;
				end
			end
			default: begin
				res_d.status = art_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	assign result = res_q;

endmodule

@@ src/allocation_range_table_top.sv @@
// Top level of the allocation range table: controller plus datapath.
// Depends on art_pkg, art_ctrl and art_dp.
//
//   channel   handshake            transfer type
//   request   start, busy          art_pkg::request_t
//   result    done (one cycle)     art_pkg::result_t
//
// Every command runs through the multiplier steps (low product, high product,
// sum), the entry scan, one memory read per cycle, a drain, the decision and
// the entry clear and write steps; a new request is taken only in idle.
// After reset a clearing pass over every entry runs with busy high.
// The receiver cannot stall; the result register holds until the next decision.
module allocation_range_table_top #(
	parameter int CAPACITY     = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  art_pkg::request_t request,
	output logic              done,
	output art_pkg::result_t  result
);

	art_pkg::ctrl_t ctrl;
	logic           idx_last;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.idx_last (idx_last),
		.busy     (busy),
		.done     (done),
		.ctrl     (ctrl)
	);

	art_dp #(
		.CAPACITY     (CAPACITY),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.request  (request),
		.idx_last (idx_last),
		.result   (result)
	);

endmodule
